// ===== rtl/core/sap_pkg.sv =====
package sap_pkg;

  // Sizing
  localparam int unsigned MAX_STAGES     = 16;
  localparam int unsigned MIN_STAGES     = 3;
  localparam int unsigned SAMPLE_BITS    = 24;
  localparam int unsigned COEF_BITS      = 24;
  localparam int unsigned COEF_FRAC      = 22;
  localparam int unsigned GAIN_BITS      = 16;
  localparam int unsigned GAIN_FRAC      = 16;
  localparam int unsigned OUT_FRAC       = 12;
  localparam int unsigned STAGE_CNT_BITS = 5;
  localparam int unsigned STAGE_IDX_BITS = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // Datapath widths: the mix value needs three bits above a sample
  localparam int unsigned MIX_BITS   = SAMPLE_BITS + 3;
  localparam int unsigned MUL_A_BITS = MIX_BITS;
  localparam int unsigned MUL_B_BITS = COEF_BITS;
  localparam int unsigned PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coeff_t;
  typedef logic signed [MIX_BITS-1:0]    mix_t;
  typedef logic signed [MUL_A_BITS-1:0]  mul_a_t;
  typedef logic signed [MUL_B_BITS-1:0]  mul_b_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;

  localparam prod_t SMAX_W = $signed({{(PROD_BITS-SAMPLE_BITS+1){1'b0}},
                                      {(SAMPLE_BITS-1){1'b1}}});
  localparam prod_t SMIN_W = $signed({{(PROD_BITS-SAMPLE_BITS+1){1'b1}},
                                      {(SAMPLE_BITS-1){1'b0}}});

  // Input and output words
  typedef struct packed {
    sample_t dry_left;
    sample_t dry_right;
    coeff_t  coeff_left;
    coeff_t  coeff_right;
  } in_word_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
  } out_word_t;

  // Configuration registers
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FEEDBACK_GAIN   = 3'd0,
    CFG_DRY_MIX         = 3'd1,
    CFG_OUTPUT_GAIN     = 3'd2,
    CFG_INVERT_WET      = 3'd3,
    CFG_INVERT_FEEDBACK = 3'd4,
    CFG_STAGE_COUNT     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0]      feedback_gain;
    logic [GAIN_BITS-1:0]      dry_mix;
    logic [GAIN_BITS-1:0]      output_gain;
    logic                      invert_wet;
    logic                      invert_feedback;
    logic [STAGE_CNT_BITS-1:0] stage_count;
  } cfg_t;

  // Lane control and result
  typedef struct packed {
    logic    start;
    sample_t dry;
    coeff_t  coeff;
  } lane_cmd_t;

  typedef struct packed {
    logic    done;
    sample_t out;
  } lane_res_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_FB_MUL,
    L_FB_ADD,
    L_STG_MUL,
    L_STG_ADD,
    L_MIX_MUL,
    L_MIX_ADD,
    L_OUT_MUL,
    L_OUT_SAT
  } lane_state_e;

endpackage

// ===== rtl/core/stereo_allpass_phaser_core.sv =====
// Stereo phaser: each input word carries a left/right sample pair and a
// per-channel allpass coefficient; each channel adds its scaled feedback,
// runs N first-order allpass stages (N = stage_count clamped to 3..16),
// mixes dry and wet, applies the output gain and saturates. Left and right
// run in two identical lanes side by side, each built around one shared
// multiplier that does the feedback product, one product per stage, the mix
// product and the gain product. No new input word is taken while one is in
// flight, but the next word is taken while the previous result still waits
// in the output register. Configure only while idle; cfg_ready_o is always
// high.
module stereo_allpass_phaser_core import sap_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_word_t                 in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_word_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      busy_q, busy_d;
  logic      in_accept;
  logic      pending;
  lane_cmd_t cmd_left, cmd_right;
  lane_res_t res_left, res_right;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FEEDBACK_GAIN:   cfg_d.feedback_gain   = cfg_data_i[GAIN_BITS-1:0];
        CFG_DRY_MIX:         cfg_d.dry_mix         = cfg_data_i[GAIN_BITS-1:0];
        CFG_OUTPUT_GAIN:     cfg_d.output_gain     = cfg_data_i[GAIN_BITS-1:0];
        CFG_INVERT_WET:      cfg_d.invert_wet      = cfg_data_i[0];
        CFG_INVERT_FEEDBACK: cfg_d.invert_feedback = cfg_data_i[0];
        CFG_STAGE_COUNT:     cfg_d.stage_count     = cfg_data_i[STAGE_CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.feedback_gain   <= '0;
      cfg_q.dry_mix         <= '0;
      cfg_q.output_gain     <= GAIN_BITS'(4096);
      cfg_q.invert_wet      <= 1'b0;
      cfg_q.invert_feedback <= 1'b0;
      cfg_q.stage_count     <= STAGE_CNT_BITS'(4);
      busy_q                <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      busy_q <= busy_d;
    end
  end

  // Input handshake: one word in flight, held off while a result is parked
  assign in_stall_o = busy_q || pending;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    if (in_accept) begin
      busy_d = 1'b1;
    end else if (res_left.done) begin
      busy_d = 1'b0;
    end
  end

  assign cmd_left.start  = in_accept;
  assign cmd_left.dry    = in_word_i.dry_left;
  assign cmd_left.coeff  = in_word_i.coeff_left;
  assign cmd_right.start = in_accept;
  assign cmd_right.dry   = in_word_i.dry_right;
  assign cmd_right.coeff = in_word_i.coeff_right;

  sap_lane u_lane_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd_left),
    .res_o  (res_left)
  );

  sap_lane u_lane_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd_right),
    .res_o  (res_right)
  );

  sap_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .left_i      (res_left),
    .right_i     (res_right),
    .out_stall_i (out_stall_i),
    .pending_o   (pending),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== rtl/core/sap_lane.sv =====
module sap_lane import sap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  lane_cmd_t cmd_i,
  output lane_res_t res_o
);

  // Saturate a wide value to a sample
  function automatic sample_t sat_s(input prod_t v);
    sample_t r;
    if (v > SMAX_W) begin
      r = SMAX_W[SAMPLE_BITS-1:0];
    end else if (v < SMIN_W) begin
      r = SMIN_W[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  // Shift right with round half up
  function automatic prod_t rnd_shift(input prod_t p, input int unsigned s);
    prod_t half;
    half = prod_t'(1) << (s - 1);
    return (p + half) >>> s;
  endfunction

  lane_state_e               state_q, state_d;
  logic [STAGE_IDX_BITS-1:0] k_q, k_d;
  logic [STAGE_IDX_BITS-1:0] last_q, last_d;
  logic [STAGE_IDX_BITS-1:0] last_cfg;
  sample_t                   dry_q, dry_d;
  coeff_t                    coeff_q, coeff_d;
  sample_t                   x_q, x_d;
  sample_t                   xprev_q, xprev_d;
  sample_t                   yold_q, yold_d;
  sample_t                   prior_q, prior_d;
  sample_t                   fb_q, fb_d;
  sample_t                   out_q, out_d;
  mix_t                      mix_q, mix_d;
  prod_t                     prod_q, prod_d;
  logic                      done_q, done_d;
  sample_t                   stg_q [MAX_STAGES];
  logic                      stg_we;
  sample_t                   stg_wdata;
  sample_t                   yold;
  mul_a_t                    mul_a;
  mul_b_t                    mul_b;
  prod_t                     mix_w;

  // Clamp the configured stage count to the supported range
  always_comb begin
    if (cfg_i.stage_count < STAGE_CNT_BITS'(MIN_STAGES)) begin
      last_cfg = STAGE_IDX_BITS'(MIN_STAGES - 1);
    end else if (int'(cfg_i.stage_count) > MAX_STAGES) begin
      last_cfg = STAGE_IDX_BITS'(MAX_STAGES - 1);
    end else begin
      last_cfg = STAGE_IDX_BITS'(cfg_i.stage_count - 1'b1);
    end
  end

  assign yold = stg_q[k_q];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      L_FB_MUL: begin
        mul_a = mul_a_t'(fb_q);
        mul_b = mul_b_t'($signed({1'b0, cfg_i.feedback_gain}));
      end
      L_STG_MUL: begin
        mul_a = mul_a_t'(x_q) - mul_a_t'(yold);
        mul_b = mul_b_t'(coeff_q);
      end
      L_MIX_MUL: begin
        if (cfg_i.invert_wet) begin
          mul_a = mul_a_t'(dry_q) + mul_a_t'(x_q);
        end else begin
          mul_a = mul_a_t'(dry_q) - mul_a_t'(x_q);
        end
        mul_b = mul_b_t'($signed({1'b0, cfg_i.dry_mix}));
      end
      L_OUT_MUL: begin
        mul_a = mul_a_t'(mix_q);
        mul_b = mul_b_t'($signed({1'b0, cfg_i.output_gain}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Wet mix before output gain
  always_comb begin
    if (cfg_i.invert_wet) begin
      mix_w = rnd_shift(prod_q, GAIN_FRAC) - prod_t'(x_q);
    end else begin
      mix_w = rnd_shift(prod_q, GAIN_FRAC) + prod_t'(x_q);
    end
  end

  // Sequencer: feedback, stage loop, mix, output gain
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    last_d    = last_q;
    dry_d     = dry_q;
    coeff_d   = coeff_q;
    x_d       = x_q;
    xprev_d   = xprev_q;
    yold_d    = yold_q;
    prior_d   = prior_q;
    fb_d      = fb_q;
    out_d     = out_q;
    mix_d     = mix_q;
    done_d    = 1'b0;
    stg_we    = 1'b0;
    stg_wdata = '0;
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          dry_d   = cmd_i.dry;
          coeff_d = cmd_i.coeff;
          last_d  = last_cfg;
          state_d = L_FB_MUL;
        end
      end
      L_FB_MUL: begin
        state_d = L_FB_ADD;
      end
      L_FB_ADD: begin
        x_d     = sat_s(prod_t'(dry_q) + rnd_shift(prod_q, GAIN_FRAC));
        xprev_d = prior_q;
        prior_d = x_d;
        k_d     = '0;
        state_d = L_STG_MUL;
      end
      L_STG_MUL: begin
        yold_d  = yold;
        state_d = L_STG_ADD;
      end
      L_STG_ADD: begin
        stg_wdata = sat_s(rnd_shift(prod_q, COEF_FRAC) + prod_t'(xprev_q));
        stg_we    = 1'b1;
        x_d       = stg_wdata;
        xprev_d   = yold_q;
        if (k_q == last_q) begin
          state_d = L_MIX_MUL;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = L_STG_MUL;
        end
      end
      L_MIX_MUL: begin
        state_d = L_MIX_ADD;
      end
      L_MIX_ADD: begin
        mix_d = mix_w[MIX_BITS-1:0];
        // stored feedback for the next sample
        if (cfg_i.invert_feedback) begin
          fb_d = sat_s(-prod_t'(x_q));
        end else begin
          fb_d = x_q;
        end
        state_d = L_OUT_MUL;
      end
      L_OUT_MUL: begin
        state_d = L_OUT_SAT;
      end
      L_OUT_SAT: begin
        out_d   = sat_s(rnd_shift(prod_q, OUT_FRAC));
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      k_q     <= '0;
      last_q  <= '0;
      prior_q <= '0;
      fb_q    <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        stg_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      last_q  <= last_d;
      prior_q <= prior_d;
      fb_q    <= fb_d;
      done_q  <= done_d;
      if (stg_we) begin
        stg_q[k_q] <= stg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dry_q   <= dry_d;
    coeff_q <= coeff_d;
    x_q     <= x_d;
    xprev_q <= xprev_d;
    yold_q  <= yold_d;
    out_q   <= out_d;
    mix_q   <= mix_d;
    prod_q  <= prod_d;
  end

  assign res_o.done = done_q;
  assign res_o.out  = out_q;

endmodule

// ===== rtl/core/sap_merge.sv =====
module sap_merge import sap_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_res_t left_i,
  input  lane_res_t right_i,
  input  logic      out_stall_i,
  output logic      pending_o,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  logic      pending_q, pending_d;
  logic      valid_q, valid_d;
  out_word_t word_q, word_d;
  logic      both_done;
  logic      slot_free;
  logic      load;

  // Both lanes run in lockstep; the pair is one output word
  assign both_done = left_i.done & right_i.done;
  assign slot_free = !valid_q || !out_stall_i;
  assign load      = (both_done || pending_q) && slot_free;

  always_comb begin
    valid_d   = valid_q;
    pending_d = pending_q;
    word_d    = word_q;
    if (load) begin
      valid_d            = 1'b1;
      pending_d          = 1'b0;
      word_d.out_left    = left_i.out;
      word_d.out_right   = right_i.out;
    end else begin
      if (!out_stall_i) begin
        valid_d = 1'b0;
      end
      if (both_done) begin
        pending_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign pending_o   = pending_q;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== rtl/core/sap_checker.sv =====
module sap_checker import sap_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // A stalled result word stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled result word does not change
  a_out_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // After taking a word the block is busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // A new result only appears after the block was busy with a word
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a word in flight");

endmodule

bind stereo_allpass_phaser_core sap_checker u_sap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
